/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level of the Ascii85 stream decoder.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A85_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A85_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/a85_pkg.sv */
// Package of the Ascii85 stream decoder: character codes, status codes and
// the step types shared by the step unit and the top level. No dependencies.
package a85_pkg;

   typedef enum logic [1:0] {
      STATUS_RUN  = 2'd0,
      STATUS_DONE = 2'd1,
      STATUS_ERR  = 2'd2
   } status_type;

   localparam logic [7:0] CHAR_FIRST_DIGIT = 8'h21;  // '!'
   localparam logic [7:0] CHAR_LAST_DIGIT  = 8'h75;  // 'u'
   localparam logic [7:0] CHAR_ZERO_GROUP  = 8'h7A;  // 'z'
   localparam logic [7:0] CHAR_TILDE       = 8'h7E;  // '~'
   localparam logic [7:0] CHAR_GREATER     = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_NUL         = 8'h00;
   localparam logic [7:0] CHAR_TAB         = 8'h09;
   localparam logic [7:0] CHAR_LF          = 8'h0A;
   localparam logic [7:0] CHAR_FF          = 8'h0C;
   localparam logic [7:0] CHAR_CR          = 8'h0D;
   localparam logic [7:0] CHAR_SPACE       = 8'h20;

   localparam int         RADIX       = 85;
   localparam int         SCALE_WIDTH = 20;
   localparam logic [2:0] GROUP_LAST  = 3'd4;

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  count;
      logic        tilde;
      status_type  status;
   } group_state_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  num_bytes;
      status_type  status;
   } step_result_type;

   // Padding n missing digits with 'u' (digit 84) turns v into
   // (v + 1) * 85^n - 1, so a closing group needs only one scale factor.
   function automatic logic [SCALE_WIDTH-1:0] pad_scale(input logic [2:0] count);
      logic [SCALE_WIDTH-1:0] scale;
      case (count)
         3'd2:    scale = SCALE_WIDTH'(RADIX * RADIX * RADIX);
         3'd3:    scale = SCALE_WIDTH'(RADIX * RADIX);
         3'd4:    scale = SCALE_WIDTH'(RADIX);
         default: scale = SCALE_WIDTH'(1);
      endcase
      return scale;
   endfunction

endpackage

/* hw/rtl/a85_req_if.sv */
// Request channel of the Ascii85 stream decoder: one text character or an
// end of input marker per request. No dependencies.
interface a85_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] char_in;

   modport source (output valid, output mode, output char_in, input ready);
   modport sink   (input valid, input mode, input char_in, output ready);
endinterface

/* hw/rtl/a85_rsp_if.sv */
// Result channel of the Ascii85 stream decoder: one decoded byte slot with
// its status per transfer. No dependencies.
interface a85_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       byte_valid;
   logic       last;
   logic [1:0] status;

   modport source (output valid, output byte_out, output byte_valid, output last,
                   output status, input ready);
   modport sink   (input valid, input byte_out, input byte_valid, input last,
                   input status, output ready);
endinterface

/* hw/rtl/ascii85_stream_decoder_top.sv */
// Ascii85 stream decoder, top level: input register, step unit, result buffer.
// Depends on a85_pkg, a85_req_if, a85_rsp_if, a85_step_unit, assert_macros.svh.
//
// Usage: each request carries one text character (mode 0) or an end of input
// marker (mode 1). Every request gives one to four results on the rsp channel;
// the final one has last set. A result with byte_valid low carries only the
// status (0 running, 1 finished after "~>", 2 malformed input, sticky).
// Order: a request is captured in the input register when accepted; its
// step result moves into the result buffer, where it is offered, once that
// buffer is free. Throughput: one request per cycle while each gives a single
// result and the receiver is ready; a request that releases k bytes holds the
// result buffer until all k have left, since the rsp channel moves one byte
// per cycle while ready is high. A request waiting in the input register
// enters the buffer in the cycle the last result of the previous one leaves.
// Reset clears the group state, the status and both pipeline stages.
// When the receiver stalls, the current result holds; once the input register
// holds a request it keeps it, and req ready drops until the buffer drains.
`include "assert_macros.svh"

module ascii85_stream_decoder_top
   import a85_pkg::*;
(
   input logic       clock,
   input logic       reset,
   a85_req_if.sink   req_if,
   a85_rsp_if.source rsp_if
);

   logic            in_valid_ff;
   logic            in_mode_ff;
   logic [7:0]      in_char_ff;

   group_state_type state_ff;
   group_state_type state_in;
   step_result_type step_result;

   logic            out_valid_ff;
   logic [31:0]     out_word_ff;
   logic [1:0]      out_last_idx_ff;
   logic [1:0]      out_idx_ff;
   logic            out_has_bytes_ff;
   status_type      out_status_ff;

   logic            out_last;
   logic            drain_done;
   logic            buf_free;
   logic            advance;

   assign out_last   = (out_idx_ff == out_last_idx_ff);
   assign drain_done = out_valid_ff && rsp_if.ready && out_last;
   assign buf_free   = !out_valid_ff || drain_done;
   assign advance    = in_valid_ff && buf_free;

   assign req_if.ready = !in_valid_ff || buf_free;

   a85_step_unit u_step (
      .state_cur (state_ff),
      .mode      (in_mode_ff),
      .char_in   (in_char_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.ready && req_if.valid) begin
         in_mode_ff <= req_if.mode;
         in_char_ff <= req_if.char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{value: 32'd0, count: 3'd0, tilde: 1'b0, status: STATUS_RUN};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_idx_ff   <= 2'd0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
         out_idx_ff   <= 2'd0;
      end else if (drain_done) begin
         out_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_if.ready) begin
         out_idx_ff <= out_idx_ff + 2'd1;
      end
      if (advance) begin
         out_word_ff      <= step_result.word;
         out_has_bytes_ff <= (step_result.num_bytes != 3'd0);
         out_last_idx_ff  <= (step_result.num_bytes == 3'd0) ? 2'd0
                                                             : 2'(step_result.num_bytes - 3'd1);
         out_status_ff    <= step_result.status;
      end
   end

   // Bytes leave most significant first.
   always_comb begin
      case (out_idx_ff)
         2'd0:    rsp_if.byte_out = out_word_ff[31:24];
         2'd1:    rsp_if.byte_out = out_word_ff[23:16];
         2'd2:    rsp_if.byte_out = out_word_ff[15:8];
         default: rsp_if.byte_out = out_word_ff[7:0];
      endcase
      if (!out_has_bytes_ff) begin
         rsp_if.byte_out = 8'd0;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.byte_valid = out_has_bytes_ff;
   assign rsp_if.last       = out_last;
   assign rsp_if.status     = out_status_ff;

   `A85_ASSERT_NEXT(a_error_sticky, clock, reset, state_ff.status == STATUS_ERR, state_ff.status == STATUS_ERR, "error status was cleared without reset")
   `A85_ASSERT_NEXT(a_stall_holds_slot, clock, reset, out_valid_ff && !rsp_if.ready, out_valid_ff && (out_idx_ff == $past(out_idx_ff)), "result slot moved during a stall")
   `A85_ASSERT_NEXT(a_load_starts_group, clock, reset, advance, out_valid_ff && (out_idx_ff == 2'd0), "result buffer did not start a new request at its first slot")
   `A85_ASSERT_SAME(a_idx_in_range, clock, reset, out_valid_ff, out_idx_ff <= out_last_idx_ff, "result index ran past the last result")

endmodule

/* hw/rtl/a85_step_unit.sv */
// Combinational step of the Ascii85 decoder: folds one request into the group
// state and gives the bytes it releases. Depends on a85_pkg.
module a85_step_unit
   import a85_pkg::*;
(
   input  group_state_type state_cur,
   input  logic            mode,
   input  logic [7:0]      char_in,
   output group_state_type state_nxt,
   output step_result_type result
);

   logic                    is_digit;
   logic                    is_skip;
   logic [6:0]              digit;
   logic [31:0]             mul_a;
   logic [SCALE_WIDTH-1:0]  mul_b;
   logic [31+SCALE_WIDTH:0] product_full;
   logic [31:0]             product;
   logic [31:0]             accum;
   logic [31:0]             padded;

   assign is_digit = (char_in >= CHAR_FIRST_DIGIT) && (char_in <= CHAR_LAST_DIGIT);
   assign is_skip  = (char_in == CHAR_NUL) || (char_in == CHAR_TAB) ||
                     (char_in == CHAR_LF) || (char_in == CHAR_FF) ||
                     (char_in == CHAR_CR) || (char_in == CHAR_SPACE);
   assign digit    = 7'(char_in - CHAR_FIRST_DIGIT);

   // One multiplier serves both the digit fold and the closing pad.
   assign mul_a        = state_cur.tilde ? (state_cur.value + 32'd1) : state_cur.value;
   assign mul_b        = state_cur.tilde ? pad_scale(state_cur.count)
                                         : SCALE_WIDTH'(RADIX);
   assign product_full = {{SCALE_WIDTH{1'b0}}, mul_a} * {32'd0, mul_b};
   assign product      = product_full[31:0];
   assign accum        = product + {25'd0, digit};
   assign padded       = product - 32'd1;

   always_comb begin
      state_nxt        = state_cur;
      result.word      = 32'd0;
      result.num_bytes = 3'd0;
      if (state_cur.status == STATUS_RUN) begin
         if (mode) begin
            state_nxt.status = STATUS_ERR;
         end else if (state_cur.tilde) begin
            if ((char_in != CHAR_GREATER) || (state_cur.count == 3'd1)) begin
               state_nxt.status = STATUS_ERR;
            end else begin
               if (state_cur.count > 3'd1) begin
                  result.word      = padded;
                  result.num_bytes = state_cur.count - 3'd1;
               end
               state_nxt.count  = 3'd0;
               state_nxt.value  = 32'd0;
               state_nxt.status = STATUS_DONE;
            end
         end else if (is_digit) begin
            if (state_cur.count == GROUP_LAST) begin
               result.word      = accum;
               result.num_bytes = 3'd4;
               state_nxt.value  = 32'd0;
               state_nxt.count  = 3'd0;
            end else begin
               state_nxt.value = accum;
               state_nxt.count = state_cur.count + 3'd1;
            end
         end else if (char_in == CHAR_ZERO_GROUP) begin
            if (state_cur.count != 3'd0) begin
               state_nxt.status = STATUS_ERR;
            end else begin
               result.num_bytes = 3'd4;
            end
         end else if (char_in == CHAR_TILDE) begin
            if (state_cur.count == 3'd1) begin
               state_nxt.status = STATUS_ERR;
            end else begin
               state_nxt.tilde = 1'b1;
            end
         end else if (!is_skip) begin
            state_nxt.status = STATUS_ERR;
         end
      end
      result.status = state_nxt.status;
   end

endmodule

/* bench/tb_ascii85_stream_decoder_top.sv */
// Self-checking testbench of the Ascii85 stream decoder top level.
// Depends on a85_pkg, a85_req_if, a85_rsp_if and ascii85_stream_decoder_top.
`timescale 1ns / 100ps

module tb_ascii85_stream_decoder_top;
   import a85_pkg::*;

   localparam int RANDOM_ITEMS = 120;
   localparam int STICKY_ITEMS = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int TIMEOUT_NS   = 5_000_000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       data_valid;
      logic       last;
      status_type status;
   } a85_byte_type;

   // One request, with its result typed in where it is obvious.
   typedef struct packed {
      logic        mode;
      logic [7:0]  ch;
      logic        typed;
      logic [2:0]  nbytes;
      logic [31:0] word;
      status_type  status;
   } stim_row_type;

   typedef enum int {
      CLOSE_PLAIN,
      CLOSE_PAD2,
      CLOSE_PAD3,
      CLOSE_PAD4,
      CLOSE_BAD_CHAR,
      CLOSE_Z_IN_GROUP,
      CLOSE_LONE_DIGIT,
      CLOSE_BROKEN_TAIL,
      CLOSE_EARLY_END
   } close_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   a85_req_if req_if ();
   a85_rsp_if rsp_if ();

   ascii85_stream_decoder_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decoder state as the testbench sees it.
   logic [31:0] acc_value     = 32'h0;
   logic [2:0]  acc_count     = 3'd0;
   logic        tilde_pending = 1'b0;
   status_type  stream_status = STATUS_RUN;

   a85_byte_type step_bytes [4];
   a85_byte_type decoded_q [$];
   int           mismatch_count = 0;
   bit           hold_off_due   = 1'b0;
   bit           idle_on        = 1'b1;

   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{1'b0, CHAR_SPACE,       1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_NUL,         1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_TAB,         1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_LF,          1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_FF,          1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_CR,          1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_FIRST_DIGIT, 1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_FIRST_DIGIT, 1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_FIRST_DIGIT, 1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_FIRST_DIGIT, 1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_FIRST_DIGIT, 1'b1, 3'd4, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_ZERO_GROUP,  1'b1, 3'd4, 32'h0000_0000, STATUS_RUN},
      '{1'b0, 8'h73,            1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, 8'h38,            1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, 8'h57,            1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, 8'h2D,            1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_FIRST_DIGIT, 1'b1, 3'd4, 32'hFFFF_FFFF, STATUS_RUN},
      '{1'b0, CHAR_LAST_DIGIT,  1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_LAST_DIGIT,  1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_LAST_DIGIT,  1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_LAST_DIGIT,  1'b1, 3'd0, 32'h0000_0000, STATUS_RUN},
      // Five 'u' digits are worth 85^5 - 1, which wraps modulo 2^32.
      '{1'b0, CHAR_LAST_DIGIT,  1'b1, 3'd4, 32'h0878_0EC4, STATUS_RUN},
      '{1'b0, 8'h39,            1'b0, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, CHAR_SPACE,       1'b0, 3'd0, 32'h0000_0000, STATUS_RUN},
      '{1'b0, 8'h6A,            1'b0, 3'd0, 32'h0000_0000, STATUS_RUN}
   };

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_NUL || c == CHAR_TAB || c == CHAR_LF || c == CHAR_FF ||
             c == CHAR_CR || c == CHAR_SPACE;
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_FIRST_DIGIT + 8'($urandom_range(0, RADIX - 1));
   endfunction

   function automatic stim_row_type request_row(input logic m, input logic [7:0] c);
      return '{m, c, 1'b0, 3'd0, 32'h0, STATUS_RUN};
   endfunction

   // Mostly back to back, sometimes short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Advances the decoder state by one request and leaves its results in
   // step_bytes; returns how many there are.
   function automatic int decode_step(input logic m, input logic [7:0] c);
      logic [31:0] word;
      int          nbytes;
      int          i;
      word   = 32'h0;
      nbytes = 0;
      if (stream_status == STATUS_RUN) begin
         if (m) begin
            stream_status = STATUS_ERR;
         end else if (tilde_pending) begin
            if (c != CHAR_GREATER || acc_count == 3'd1) begin
               stream_status = STATUS_ERR;
            end else begin
               // Missing digits of a closing group count as 'u'.
               if (acc_count > 3'd1) begin
                  word = acc_value;
                  for (i = int'(acc_count); i < 5; i++) begin
                     word = word * RADIX + 32'(CHAR_LAST_DIGIT - CHAR_FIRST_DIGIT);
                  end
                  nbytes = int'(acc_count) - 1;
               end
               acc_value     = 32'h0;
               acc_count     = 3'd0;
               stream_status = STATUS_DONE;
            end
         end else if (c >= CHAR_FIRST_DIGIT && c <= CHAR_LAST_DIGIT) begin
            acc_value = acc_value * RADIX + 32'(c - CHAR_FIRST_DIGIT);
            acc_count = acc_count + 3'd1;
            if (acc_count == 3'd5) begin
               word      = acc_value;
               nbytes    = 4;
               acc_value = 32'h0;
               acc_count = 3'd0;
            end
         end else if (c == CHAR_ZERO_GROUP) begin
            if (acc_count != 3'd0) begin
               stream_status = STATUS_ERR;
            end else begin
               nbytes = 4;
            end
         end else if (c == CHAR_TILDE) begin
            if (acc_count == 3'd1) begin
               stream_status = STATUS_ERR;
            end else begin
               tilde_pending = 1'b1;
            end
         end else if (!is_blank(c)) begin
            stream_status = STATUS_ERR;
         end
      end
      if (nbytes == 0) begin
         step_bytes[0] = '{8'h00, 1'b0, 1'b1, stream_status};
         return 1;
      end
      for (i = 0; i < nbytes; i++) begin
         step_bytes[i] = '{word[31 - 8 * i -: 8], 1'b1, i == nbytes - 1, stream_status};
      end
      return nbytes;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      end
      mismatch_count++;
   endtask

   task automatic send_request(input stim_row_type row);
      int gap;
      int n;
      int k;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.mode    <= row.mode;
      req_if.char_in <= row.ch;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      n = decode_step(row.mode, row.ch);
      if (row.typed && row.nbytes == 3'd0) begin
         decoded_q.push_back('{8'h00, 1'b0, 1'b1, row.status});
      end else if (row.typed) begin
         for (k = 0; k < row.nbytes; k++) begin
            decoded_q.push_back('{row.word[31 - 8 * k -: 8], 1'b1, k == row.nbytes - 1,
                                  row.status});
         end
      end else begin
         for (k = 0; k < n; k++) decoded_q.push_back(step_bytes[k]);
      end
   endtask

   initial begin : drive_requests
      int             n;
      int             roll;
      int             pending;
      int             hold_at;
      int             quiet_from;
      logic [7:0]     c;
      close_kind_type closing;

      req_if.valid   <= 1'b0;
      req_if.mode    <= 1'b0;
      req_if.char_in <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) send_request(DIRECTED_ROWS[i]);

      // Well-formed text only: any malformed request would freeze the
      // status for the rest of the run.
      hold_at    = $urandom_range(20, 100);
      quiet_from = $urandom_range(0, RANDOM_ITEMS - 30);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == hold_at) hold_off_due = 1'b1;
         idle_on = !(n >= quiet_from && n < quiet_from + 30);
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            case ($urandom_range(0, 5))
               0:       c = CHAR_NUL;
               1:       c = CHAR_TAB;
               2:       c = CHAR_LF;
               3:       c = CHAR_FF;
               4:       c = CHAR_CR;
               default: c = CHAR_SPACE;
            endcase
         end else if (roll < 22 && acc_count == 3'd0) begin
            c = CHAR_ZERO_GROUP;
         end else begin
            c = random_digit();
         end
         send_request(request_row(1'b0, c));
      end
      idle_on = 1'b1;

      // Close the stream in one of the ways that end it, then keep sending
      // anything at all to see that the final status sticks.
      closing = close_kind_type'($urandom_range(CLOSE_PLAIN, CLOSE_EARLY_END));
      while (acc_count != 3'd0) send_request(request_row(1'b0, random_digit()));
      case (closing)
         CLOSE_PLAIN:      pending = 0;
         CLOSE_PAD2:       pending = 2;
         CLOSE_PAD3:       pending = 3;
         CLOSE_PAD4:       pending = 4;
         CLOSE_Z_IN_GROUP: pending = $urandom_range(1, 4);
         CLOSE_LONE_DIGIT: pending = 1;
         default:          pending = $urandom_range(0, 4);
      endcase
      repeat (pending) send_request(request_row(1'b0, random_digit()));
      case (closing)
         CLOSE_BAD_CHAR: begin
            do begin
               c = 8'($urandom_range(0, 255));
            end while ((c >= CHAR_FIRST_DIGIT && c <= CHAR_LAST_DIGIT) ||
                       c == CHAR_ZERO_GROUP || c == CHAR_TILDE || is_blank(c));
            send_request(request_row(1'b0, c));
         end
         CLOSE_Z_IN_GROUP: begin
            send_request(request_row(1'b0, CHAR_ZERO_GROUP));
         end
         CLOSE_LONE_DIGIT: begin
            send_request(request_row(1'b0, CHAR_TILDE));
         end
         CLOSE_BROKEN_TAIL: begin
            send_request(request_row(1'b0, CHAR_TILDE));
            do begin
               c = 8'($urandom_range(0, 255));
            end while (c == CHAR_GREATER);
            send_request(request_row(1'b0, c));
         end
         CLOSE_EARLY_END: begin
            send_request(request_row(1'b1, 8'($urandom_range(0, 255))));
         end
         default: begin
            send_request(request_row(1'b0, CHAR_TILDE));
            send_request(request_row(1'b0, CHAR_GREATER));
         end
      endcase
      repeat (STICKY_ITEMS) begin
         send_request(request_row(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
      end
      req_if.valid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off that backs the block up
   // into its request channel.
   initial begin : drive_ready
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      a85_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("result with no request pending", 32'(rsp_if.byte_out), 32'h0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_if.byte_out !== want.data)
               report_mismatch("byte_out", 32'(rsp_if.byte_out), 32'(want.data));
            if (rsp_if.byte_valid !== want.data_valid)
               report_mismatch("byte_valid", 32'(rsp_if.byte_valid), 32'(want.data_valid));
            if (rsp_if.last !== want.last)
               report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
            if (rsp_if.status !== want.status)
               report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
